// File: design/pee_pkg.sv
// Shared types, constants and command structs for the postfix expression evaluator.
package pee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DCNT_W      = $clog2(VALUE_WIDTH + 1);
  localparam int STATUS_W    = 3;
  localparam int OUT_DATA_W  = ((VALUE_WIDTH + STATUS_W + 7) / 8) * 8;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_INVALID = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5
  } alu_op_t;

  typedef struct packed {
    logic             we;
    logic             wsel_alu;
    logic [PTR_W-1:0] waddr;
    logic [3:0]       digit;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } stk_cmd_t;

  typedef struct packed {
    logic    load_b;
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic divzero;
  } alu_sts_t;

endpackage

// File: design/postfix_expression_evaluator.sv
// Postfix expression evaluator top level: controller, operand stack and arithmetic unit.
// One character word at a time; a new word is taken only once the previous one is done.
// Division and remainder work one quotient bit per cycle, save for a zero divisor; ^ takes
// a multiply and a squaring step per exponent bit up to its highest set bit, save for a
// negative exponent. A last word also passes through the result emit state.
// Synchronous active-low reset empties the stack and clears the error and output valid.
module postfix_expression_evaluator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] token
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pee_pkg::OUT_DATA_W-1:0] out_tdata   // [31:0] value, [34:32] status
);

  pee_pkg::stk_cmd_t               stk_cmd;
  pee_pkg::alu_cmd_t               alu_cmd;
  pee_pkg::alu_sts_t               alu_sts;
  logic [pee_pkg::VALUE_WIDTH-1:0] rdata;
  logic [pee_pkg::VALUE_WIDTH-1:0] alu_res;
  logic [pee_pkg::VALUE_WIDTH-1:0] out_value;
  logic [pee_pkg::STATUS_W-1:0]    out_status;

  assign out_tdata = pee_pkg::OUT_DATA_W'({out_status, out_value});

  pee_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_token   (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_status (out_status),
    .stk_cmd    (stk_cmd),
    .rdata      (rdata),
    .alu_cmd    (alu_cmd),
    .alu_sts    (alu_sts)
  );

  pee_stack u_stack (
    .clk     (clk),
    .cmd     (stk_cmd),
    .alu_res (alu_res),
    .rdata   (rdata)
  );

  pee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .opnd  (rdata),
    .sts   (alu_sts),
    .res   (alu_res)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous word still in work");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    alu_cmd.start |-> !alu_sts.busy)
    else $error("arithmetic unit started while busy");

  a_writeback_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.we && stk_cmd.wsel_alu |-> alu_sts.done)
    else $error("stack written with an unfinished result");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a word in work");

endmodule

// File: design/pee_stack.sv
// Operand stack memory with one write port and one registered read port.
module pee_stack (
  input  logic                            clk,
  input  pee_pkg::stk_cmd_t               cmd,
  input  logic [pee_pkg::VALUE_WIDTH-1:0] alu_res,
  output logic [pee_pkg::VALUE_WIDTH-1:0] rdata
);

  logic [pee_pkg::VALUE_WIDTH-1:0] mem [pee_pkg::STACK_DEPTH];
  logic [pee_pkg::VALUE_WIDTH-1:0] wdata;
  logic [pee_pkg::VALUE_WIDTH-1:0] rdata_r;

  assign wdata = cmd.wsel_alu ? alu_res : pee_pkg::VALUE_WIDTH'(cmd.digit);
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem[cmd.raddr];
    end
  end

endmodule

// File: design/pee_alu.sv
// Arithmetic unit: add, subtract, multiply, bit-serial divide and remainder, and iterative power.
module pee_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pee_pkg::alu_cmd_t               cmd,
  input  logic [pee_pkg::VALUE_WIDTH-1:0] opnd,
  output pee_pkg::alu_sts_t               sts,
  output logic [pee_pkg::VALUE_WIDTH-1:0] res
);

  localparam int W = pee_pkg::VALUE_WIDTH;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_POW  = 4'b1000
  } alu_state_t;

  alu_state_t st_r, st_nxt;
  logic       done_r, done_nxt;

  logic [W-1:0]              b_r, b_nxt;
  logic [W-1:0]              acc_r, acc_nxt;
  logic [W-1:0]              sq_r, sq_nxt;
  logic [W-1:0]              q_r, q_nxt;
  logic [W-1:0]              rem_r, rem_nxt;
  logic [pee_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                      negq_r, negq_nxt;
  logic                      negr_r, negr_nxt;
  logic                      mod_r, mod_nxt;
  logic                      phase_r, phase_nxt;
  logic [W-1:0]              res_r, res_nxt;
  logic                      dz_r, dz_nxt;

  logic [W-1:0] mag_a, mag_b, mul_x, prod;
  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] rem_new, q_new;

  assign mag_a   = opnd[W-1] ? (~opnd + 1'b1) : opnd;
  assign mag_b   = b_r[W-1] ? (~b_r + 1'b1) : b_r;
  assign mul_x   = ((st_r == A_POW) && phase_r) ? sq_r : acc_r;
  assign prod    = mul_x * sq_r;
  assign trial   = {rem_r, q_r[W-1]};
  assign ge      = trial >= {1'b0, b_r};
  assign rem_new = ge ? W'(trial - {1'b0, b_r}) : trial[W-1:0];
  assign q_new   = {q_r[W-2:0], ge};

  assign sts.busy    = (st_r != A_IDLE);
  assign sts.done    = done_r;
  assign sts.divzero = dz_r;
  assign res         = res_r;

  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    negq_nxt  = negq_r;
    negr_nxt  = negr_r;
    mod_nxt   = mod_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    dz_nxt    = dz_r;
    if (cmd.load_b) begin
      b_nxt = opnd;
    end
    case (st_r)
      A_IDLE: begin
        if (cmd.start) begin
          dz_nxt = 1'b0;
          case (cmd.op)
            pee_pkg::OP_ADD: begin
              res_nxt  = opnd + b_r;
              done_nxt = 1'b1;
            end
            pee_pkg::OP_SUB: begin
              res_nxt  = opnd - b_r;
              done_nxt = 1'b1;
            end
            pee_pkg::OP_MUL: begin
              acc_nxt = opnd;
              sq_nxt  = b_r;
              st_nxt  = A_MUL;
            end
            pee_pkg::OP_DIV, pee_pkg::OP_MOD: begin
              if (b_r == '0) begin
                res_nxt  = '0;
                dz_nxt   = 1'b1;
                done_nxt = 1'b1;
              end else begin
                q_nxt    = mag_a;
                b_nxt    = mag_b;
                rem_nxt  = '0;
                cnt_nxt  = pee_pkg::DCNT_W'(W);
                negq_nxt = opnd[W-1] ^ b_r[W-1];
                negr_nxt = opnd[W-1];
                mod_nxt  = (cmd.op == pee_pkg::OP_MOD);
                st_nxt   = A_DIV;
              end
            end
            pee_pkg::OP_POW: begin
              if (b_r[W-1]) begin
                if (opnd == W'(1)) begin
                  res_nxt = W'(1);
                end else if (opnd == '1) begin
                  res_nxt = b_r[0] ? '1 : W'(1);
                end else begin
                  res_nxt = '0;
                end
                done_nxt = 1'b1;
              end else begin
                acc_nxt   = W'(1);
                sq_nxt    = opnd;
                phase_nxt = 1'b0;
                st_nxt    = A_POW;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        res_nxt  = prod;
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      A_DIV: begin
        q_nxt   = q_new;
        rem_nxt = rem_new;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == pee_pkg::DCNT_W'(1)) begin
          if (mod_r) begin
            res_nxt = negr_r ? (~rem_new + 1'b1) : rem_new;
          end else begin
            res_nxt = negq_r ? (~q_new + 1'b1) : q_new;
          end
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_POW: begin
        if (!phase_r) begin
          if (b_r == '0) begin
            res_nxt  = acc_r;
            done_nxt = 1'b1;
            st_nxt   = A_IDLE;
          end else begin
            if (b_r[0]) begin
              acc_nxt = prod;
            end
            phase_nxt = 1'b1;
          end
        end else begin
          sq_nxt    = prod;
          b_nxt     = b_r >> 1;
          phase_nxt = 1'b0;
        end
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    sq_r    <= sq_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    negq_r  <= negq_nxt;
    negr_r  <= negr_nxt;
    mod_r   <= mod_nxt;
    phase_r <= phase_nxt;
    res_r   <= res_nxt;
    dz_r    <= dz_nxt;
  end

endmodule

// File: design/pee_ctrl.sv
// Controller: token decode, stack pointer, sticky error and result register.
module pee_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_token,
  input  logic                            in_last,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pee_pkg::VALUE_WIDTH-1:0] out_value,
  output logic [pee_pkg::STATUS_W-1:0]    out_status,
  output pee_pkg::stk_cmd_t               stk_cmd,
  input  logic [pee_pkg::VALUE_WIDTH-1:0] rdata,
  output pee_pkg::alu_cmd_t               alu_cmd,
  input  pee_pkg::alu_sts_t               alu_sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RD_L   = 7'b0000100,
    S_START  = 7'b0001000,
    S_BUSY   = 7'b0010000,
    S_END    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t                     st_r, st_nxt;
  logic [pee_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  pee_pkg::status_t                err_r, err_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      tok_r, tok_nxt;
  logic                            last_r, last_nxt;
  logic                            topz_r, topz_nxt;
  logic [pee_pkg::VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  pee_pkg::status_t                out_status_r, out_status_nxt;

  logic                      note_en;
  pee_pkg::status_t          note_code;
  logic                      is_digit, is_op;
  logic [7:0]                dig_full;
  logic [pee_pkg::CNT_W-1:0] cnt_m1, cnt_m2;
  logic                      emit_ok;

  function automatic pee_pkg::alu_op_t op_of(input logic [7:0] t);
    pee_pkg::alu_op_t o;
    case (t)
      pee_pkg::CH_PLUS:  o = pee_pkg::OP_ADD;
      pee_pkg::CH_MINUS: o = pee_pkg::OP_SUB;
      pee_pkg::CH_STAR:  o = pee_pkg::OP_MUL;
      pee_pkg::CH_SLASH: o = pee_pkg::OP_DIV;
      pee_pkg::CH_PCT:   o = pee_pkg::OP_MOD;
      default:           o = pee_pkg::OP_POW;
    endcase
    return o;
  endfunction

  assign is_digit = (tok_r >= pee_pkg::CH_0) && (tok_r <= pee_pkg::CH_9);
  assign is_op    = (tok_r == pee_pkg::CH_PLUS) || (tok_r == pee_pkg::CH_MINUS) ||
                    (tok_r == pee_pkg::CH_STAR) || (tok_r == pee_pkg::CH_SLASH) ||
                    (tok_r == pee_pkg::CH_PCT)  || (tok_r == pee_pkg::CH_CARET);
  assign dig_full = tok_r - pee_pkg::CH_0;
  assign cnt_m1   = cnt_r - 1'b1;
  assign cnt_m2   = cnt_r - 2'd2;
  assign emit_ok  = !out_valid_r || out_tready;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    tok_nxt        = tok_r;
    last_nxt       = last_r;
    topz_nxt       = topz_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    note_en        = 1'b0;
    note_code      = pee_pkg::ST_OK;
    stk_cmd        = '0;
    alu_cmd        = '0;
    alu_cmd.op     = op_of(tok_r);
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tok_nxt  = in_token;
          last_nxt = in_last;
          st_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt = S_END;
        if (is_digit) begin
          if (cnt_r >= pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH)) begin
            note_en   = 1'b1;
            note_code = pee_pkg::ST_OVER;
          end else begin
            stk_cmd.we    = 1'b1;
            stk_cmd.waddr = cnt_r[pee_pkg::PTR_W-1:0];
            stk_cmd.digit = dig_full[3:0];
            cnt_nxt       = cnt_r + 1'b1;
          end
        end else if (is_op) begin
          if (cnt_r < pee_pkg::CNT_W'(2)) begin
            note_en   = 1'b1;
            note_code = pee_pkg::ST_UNDER;
          end else begin
            stk_cmd.re    = 1'b1;
            stk_cmd.raddr = cnt_m1[pee_pkg::PTR_W-1:0];
            st_nxt        = S_RD_L;
          end
        end else begin
          note_en   = 1'b1;
          note_code = pee_pkg::ST_INVALID;
        end
      end
      S_RD_L: begin
        alu_cmd.load_b = 1'b1;
        stk_cmd.re     = 1'b1;
        stk_cmd.raddr  = cnt_m2[pee_pkg::PTR_W-1:0];
        st_nxt         = S_START;
      end
      S_START: begin
        alu_cmd.start = 1'b1;
        st_nxt        = S_BUSY;
      end
      S_BUSY: begin
        if (alu_sts.done) begin
          stk_cmd.we       = 1'b1;
          stk_cmd.wsel_alu = 1'b1;
          stk_cmd.waddr    = cnt_m2[pee_pkg::PTR_W-1:0];
          cnt_nxt          = cnt_m1;
          if (alu_sts.divzero) begin
            note_en   = 1'b1;
            note_code = pee_pkg::ST_DIVZERO;
          end
          st_nxt = S_END;
        end
      end
      S_END: begin
        if (!last_r) begin
          st_nxt = S_IDLE;
        end else if (cnt_r == '0) begin
          note_en   = 1'b1;
          note_code = pee_pkg::ST_UNDER;
          topz_nxt  = 1'b1;
          st_nxt    = S_EMIT;
        end else begin
          stk_cmd.re    = 1'b1;
          stk_cmd.raddr = cnt_m1[pee_pkg::PTR_W-1:0];
          topz_nxt      = 1'b0;
          st_nxt        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_value_nxt  = topz_r ? '0 : rdata;
          out_status_nxt = err_r;
          out_valid_nxt  = 1'b1;
          cnt_nxt        = '0;
          err_nxt        = pee_pkg::ST_OK;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (note_en && (err_r == pee_pkg::ST_OK)) begin
      err_nxt = note_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= pee_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r        <= tok_nxt;
    last_r       <= last_nxt;
    topz_r       <= topz_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
